// ===== src/prlsp_pkg.sv =====
// Shared types and constants for the path record lookahead speed planner.
package prlsp_pkg;

  // Input word: one record or track tick
  typedef struct packed {
    logic               cmd;
    logic signed [23:0] distance;
    logic signed [15:0] heading;
  } in_word_t;

  // Output word: planner status after one tick
  typedef struct packed {
    logic [11:0] speed;
    logic        sampled;
    logic [9:0]  path_index;
    logic        reset_request;
  } out_word_t;

  // Configuration registers as seen by the core
  typedef struct packed {
    logic [15:0] point_spacing;
    logic [7:0]  segment_length;
    logic [11:0] speed_straight;
    logic [11:0] speed_small_curve;
    logic [11:0] speed_right_angle;
    logic [11:0] speed_sharp;
  } cfg_t;

  // Configuration register indexes
  localparam logic [2:0] REG_POINT_SPACING     = 3'd0;
  localparam logic [2:0] REG_SEGMENT_LENGTH    = 3'd1;
  localparam logic [2:0] REG_SPEED_STRAIGHT    = 3'd2;
  localparam logic [2:0] REG_SPEED_SMALL_CURVE = 3'd3;
  localparam logic [2:0] REG_SPEED_RIGHT_ANGLE = 3'd4;
  localparam logic [2:0] REG_SPEED_SHARP       = 3'd5;

  // Ratio thresholds in Q8.8 (0.7, 2.5 and 4.0 degrees per segment)
  localparam logic [15:0] RATIO_STRAIGHT = 16'd179;
  localparam logic [15:0] RATIO_SMALL    = 16'd640;
  localparam logic [15:0] RATIO_RIGHT    = 16'd1024;

  // floor(x / 60) for 12-bit x as (x * 4370) >> 18
  localparam logic [12:0] LOOK_RECIP = 13'd4370;
  localparam int          LOOK_SHIFT = 18;

  // Band width divisions as (n * m) >> 30, exact for n below 2^23
  localparam logic [21:0] BAND1_RECIP = 22'd2329158;  // divide by 461
  localparam logic [21:0] BAND2_RECIP = 22'd2796203;  // divide by 384
  localparam int          BAND_SHIFT  = 30;

  // Divider handshake between the sequencer and the shared divider
  typedef struct packed {
    logic        start;
    logic [23:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [23:0] quotient;
  } div_rsp_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_REC,
    S_TRACK,
    S_IDIV,
    S_CLAMP,
    S_PLAN,
    S_LOAD,
    S_PRIME,
    S_SEG,
    S_SDIV,
    S_STEP,
    S_MAP,
    S_MDIV,
    S_DONE
  } state_t;

endpackage

// ===== src/prlsp_div.sv =====
// Shared restoring divider: one quotient bit per cycle.
module prlsp_div
  import prlsp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic        busy;
  logic [4:0]  cnt;
  logic [15:0] rem;
  logic [23:0] quo;
  logic [15:0] dvs;
  logic        done;
  logic [16:0] trial;
  logic        fits;

  // Trial subtract of the next partial remainder
  always_comb begin
    trial = {rem, quo[23]};
    fits  = trial >= {1'b0, dvs};
  end

  // Control: count 24 steps per division
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd23) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift the dividend through, build the quotient
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
    end else if (busy) begin
      rem <= fits ? 16'(trial - {1'b0, dvs}) : trial[15:0];
      quo <= {quo[22:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// ===== src/prlsp_core.sv =====
// Sequencer, heading table and output register of the planner.
module prlsp_core
  import prlsp_pkg::*;
#(
  parameter int MAX_POINTS    = 1024,
  parameter int MAX_LOOKAHEAD = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data,
  output div_req_t  div_req,
  input  div_rsp_t  div_rsp
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);

  state_t state, state_next;

  logic [15:0]        mem [MAX_POINTS];
  logic [15:0]        rd_data;

  logic signed [23:0] dist_q;
  logic [15:0]        head_q;
  logic [7:0]         look_q;
  logic [CW-1:0]      pc;
  logic signed [23:0] last;
  logic [AW-1:0]      replay;
  logic [11:0]        planned;
  logic               sampled_q;
  logic               req_q;
  logic [AW-1:0]      idx_q;
  logic [7:0]         nseg;
  logic [7:0]         cnt;
  logic [AW-1:0]      ptr;
  logic [15:0]        prev;
  logic [15:0]        maxr;
  logic [11:0]        top_q;
  logic               neg_q;
  logic [23:0]        num_q;

  // Combinational helpers
  logic [24:0]        look_prod;
  logic [7:0]         look_full;
  logic signed [24:0] rec_diff;
  logic               rec_ok;
  logic [15:0]        sd_eff;
  logic [CW-1:0]      pc_last;
  logic [AW-1:0]      idx_clamp;
  logic [CW-1:0]      rem_pts;
  logic [7:0]         nseg_calc;
  logic signed [16:0] hd;
  logic [15:0]        ad;
  logic [15:0]        seg_q;
  logic               band1;
  logic [10:0]        r_off;
  logic [11:0]        b_top;
  logic [11:0]        b_bot;
  logic signed [12:0] delta;
  logic signed [24:0] num;
  logic [23:0]        num_abs;
  logic [45:0]        q_prod;
  logic [15:0]        q_band;
  logic signed [25:0] s_full;
  logic [11:0]        s_clamp;
  logic               can_load;

  // Lookahead length, ratio and band arithmetic
  always_comb begin
    look_prod = 25'(planned * LOOK_RECIP);
    look_full = 8'(look_prod >> LOOK_SHIFT);
    if (look_full > 8'(MAX_LOOKAHEAD)) begin
      look_full = 8'(MAX_LOOKAHEAD);
    end
    rec_diff = 25'(dist_q) - 25'(last);
    rec_ok   = (rec_diff >= $signed({9'b0, cfg.point_spacing})) &&
               (32'(pc) < 32'(MAX_POINTS));
    sd_eff   = (cfg.point_spacing == '0) ? 16'd1 : cfg.point_spacing;
    pc_last  = pc - CW'(1);
    idx_clamp = (div_rsp.quotient >= 24'(pc)) ? AW'(pc_last) :
                AW'(div_rsp.quotient);
    rem_pts  = pc_last - CW'(idx_q);
    nseg_calc = (32'(rem_pts) < 32'(look_q)) ? 8'(rem_pts) : look_q;
    hd       = $signed({rd_data[15], rd_data}) - $signed({prev[15], prev});
    ad       = hd[16] ? 16'(-hd) : hd[15:0];
    seg_q    = (div_rsp.quotient[23:16] != '0) ? 16'hFFFF : div_rsp.quotient[15:0];
    band1    = maxr <= RATIO_SMALL;
    r_off    = band1 ? 11'(maxr - RATIO_STRAIGHT) : 11'(maxr - RATIO_SMALL);
    b_top    = band1 ? cfg.speed_straight : cfg.speed_small_curve;
    b_bot    = band1 ? cfg.speed_small_curve : cfg.speed_right_angle;
    delta    = $signed({1'b0, b_top}) - $signed({1'b0, b_bot});
    num      = $signed({1'b0, r_off}) * delta;
    num_abs  = num[24] ? 24'(-num) : num[23:0];
    q_prod   = 46'(num_q * (band1 ? BAND1_RECIP : BAND2_RECIP));
    q_band   = 16'(q_prod >> BAND_SHIFT);
    s_full   = neg_q ? $signed({14'b0, top_q}) + $signed({10'b0, q_band})
                     : $signed({14'b0, top_q}) - $signed({10'b0, q_band});
    if (s_full < 0) begin
      s_clamp = '0;
    end else if (s_full > 26'sd4095) begin
      s_clamp = 12'd4095;
    end else begin
      s_clamp = s_full[11:0];
    end
    can_load = !out_valid || !out_stall;
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and divider requests
  always_comb begin
    state_next       = state;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = 16'd1;
    in_stall         = state != S_IDLE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = in_data.cmd ? S_TRACK : S_REC;
        end
      end
      S_REC: state_next = S_DONE;
      S_TRACK: begin
        if (pc == '0 || 32'(replay) >= 32'(pc)) begin
          state_next = S_DONE;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = dist_q[23] ? 24'd0 : dist_q;
          div_req.divisor  = sd_eff;
          state_next       = S_IDIV;
        end
      end
      S_IDIV: if (div_rsp.done) state_next = S_CLAMP;
      S_CLAMP: state_next = S_PLAN;
      S_PLAN: begin
        if (CW'(idx_q) == pc_last) begin
          state_next = S_DONE;
        end else if (nseg_calc == '0) begin
          state_next = S_MAP;
        end else begin
          state_next = S_LOAD;
        end
      end
      S_LOAD:  state_next = S_PRIME;
      S_PRIME: state_next = S_SEG;
      S_SEG: begin
        div_req.start    = 1'b1;
        div_req.dividend = {ad, 8'b0};
        div_req.divisor  = (cfg.segment_length == '0) ? 16'd10 :
                           16'(cfg.segment_length * 4'd10);
        state_next       = S_SDIV;
      end
      S_SDIV: begin
        if (div_rsp.done) begin
          state_next = (cnt + 8'd1 == nseg) ? S_MAP : S_STEP;
        end
      end
      S_STEP: state_next = S_SEG;
      S_MAP: begin
        if (maxr <= RATIO_STRAIGHT || maxr > RATIO_RIGHT) begin
          state_next = S_DONE;
        end else begin
          state_next = S_MDIV;
        end
      end
      S_MDIV: state_next = S_DONE;
      S_DONE: if (can_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Heading table
  always_ff @(posedge clk) begin
    if (state == S_REC && rec_ok) begin
      mem[AW'(pc)] <= head_q;
    end
    rd_data <= mem[ptr];
  end

  // Control state of the planner
  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= '0;
      last      <= '0;
      replay    <= '0;
      planned   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && can_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_REC: begin
          if (rec_ok) begin
            pc   <= pc + CW'(1);
            last <= dist_q;
          end
        end
        S_TRACK: begin
          if (pc != '0 && 32'(replay) >= 32'(pc)) begin
            pc     <= '0;
            last   <= '0;
            replay <= '0;
          end
        end
        S_CLAMP: replay <= idx_clamp;
        S_PLAN: begin
          if (CW'(idx_q) == pc_last) planned <= cfg.speed_small_curve;
        end
        S_MAP: begin
          if (maxr <= RATIO_STRAIGHT) begin
            planned <= cfg.speed_straight;
          end else if (maxr > RATIO_RIGHT) begin
            planned <= cfg.speed_sharp;
          end
        end
        S_MDIV: planned <= s_clamp;
        default: ;
      endcase
    end
  end

  // Working registers of one tick
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        dist_q    <= in_data.distance;
        head_q    <= in_data.heading;
        look_q    <= look_full;
        sampled_q <= 1'b0;
        req_q     <= 1'b0;
      end
      S_REC: if (rec_ok) sampled_q <= 1'b1;
      S_TRACK: if (pc != '0 && 32'(replay) >= 32'(pc)) req_q <= 1'b1;
      S_CLAMP: idx_q <= idx_clamp;
      S_PLAN: begin
        nseg <= nseg_calc;
        cnt  <= '0;
        maxr <= '0;
        ptr  <= idx_q;
      end
      S_LOAD:  ptr  <= ptr + AW'(1);
      S_PRIME: prev <= rd_data;
      S_SEG:   prev <= rd_data;
      S_SDIV: begin
        if (div_rsp.done) begin
          if (seg_q > maxr) maxr <= seg_q;
          cnt <= cnt + 8'd1;
          ptr <= ptr + AW'(1);
        end
      end
      S_MAP: begin
        neg_q <= num[24];
        top_q <= b_top;
        num_q <= num_abs;
      end
      S_DONE: begin
        if (can_load) begin
          out_data.speed         <= planned;
          out_data.sampled       <= sampled_q;
          out_data.path_index    <= 10'(replay);
          out_data.reset_request <= req_q;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== src/path_record_lookahead_speed_planner_top.sv =====
// Top level: configuration registers, shared divider and planner core.
//
//   channel | direction | handshake            | word
//   in      | input     | in_valid / in_stall  | in_word_t  (cmd, distance, heading)
//   out     | output    | out_valid / out_stall| out_word_t (speed, sampled, path_index,
//           |           |                      |             reset_request)
//   cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// A record tick, an empty path or a replay end needs no division. A track
// tick divides once for the index, then once per scanned segment (up to
// MAX_LOOKAHEAD), and passes S_MDIV in a linear band; no segment is scanned
// at the last point. Each division uses the 24-step shared divider.
// Reset (rst, synchronous) clears the path, the replay index and the speed.
// A stalled output holds the next result in the core until the word is taken.
module path_record_lookahead_speed_planner_top
  import prlsp_pkg::*;
#(
  parameter int MAX_POINTS    = 1024,
  parameter int MAX_LOOKAHEAD = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.point_spacing     <= 16'd34;
      cfg.segment_length    <= 8'd1;
      cfg.speed_straight    <= 12'd600;
      cfg.speed_small_curve <= 12'd450;
      cfg.speed_right_angle <= 12'd350;
      cfg.speed_sharp       <= 12'd300;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POINT_SPACING:     cfg.point_spacing     <= cfg_data;
        REG_SEGMENT_LENGTH:    cfg.segment_length    <= cfg_data[7:0];
        REG_SPEED_STRAIGHT:    cfg.speed_straight    <= cfg_data[11:0];
        REG_SPEED_SMALL_CURVE: cfg.speed_small_curve <= cfg_data[11:0];
        REG_SPEED_RIGHT_ANGLE: cfg.speed_right_angle <= cfg_data[11:0];
        REG_SPEED_SHARP:       cfg.speed_sharp       <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  prlsp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  prlsp_core #(
    .MAX_POINTS    (MAX_POINTS),
    .MAX_LOOKAHEAD (MAX_LOOKAHEAD)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .div_req   (div_req),
    .div_rsp   (div_rsp)
  );

endmodule

// ===== dv/tb.sv =====
// Testbench for the path record lookahead speed planner top level.
`timescale 1ns / 100ps

module tb;
  import prlsp_pkg::*;

  localparam int NUM_POINTS = 1024;
  localparam int LOOK_MAX   = 64;
  localparam int IDLE_LIMIT = 200000;

  // Predictor of the planner plus a queue of expected words
  class planner_scoreboard;
    logic [15:0] headings [NUM_POINTS];
    int unsigned npoints;
    int          last_pos;
    int unsigned replay;
    int unsigned cur_speed;
    int unsigned samp_dist, seg_len, sp_straight, sp_small, sp_right, sp_sharp;
    out_word_t   pending [$];
    int          errors;

    function new();
      npoints = 0; last_pos = 0; replay = 0; cur_speed = 0;
      samp_dist = 34; seg_len = 1; sp_straight = 600; sp_small = 450;
      sp_right = 350; sp_sharp = 300; errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        REG_POINT_SPACING:     samp_dist = 32'(val);
        REG_SEGMENT_LENGTH:    seg_len = 32'(val[7:0]);
        REG_SPEED_STRAIGHT:    sp_straight = 32'(val[11:0]);
        REG_SPEED_SMALL_CURVE: sp_small = 32'(val[11:0]);
        REG_SPEED_RIGHT_ANGLE: sp_right = 32'(val[11:0]);
        REG_SPEED_SHARP:       sp_sharp = 32'(val[11:0]);
        default: ;
      endcase
    endfunction

    function int unsigned seg_ratio(logic [15:0] a, logic [15:0] b);
      int d;
      int unsigned sl, r;
      d = $signed(b) - $signed(a);
      if (d < 0) d = -d;
      sl = (seg_len == 0) ? 1 : seg_len;
      r = (d * 256) / (10 * sl);
      return (r > 65535) ? 65535 : r;
    endfunction

    function int unsigned band(int unsigned r, int lo, int hi, int top, int bot);
      int s;
      s = top - ((int'(r) - lo) * (top - bot)) / (hi - lo);
      if (s < 0) s = 0;
      if (s > 4095) s = 4095;
      return s;
    endfunction

    function int unsigned map_speed(int unsigned r);
      if (r <= RATIO_STRAIGHT) return sp_straight;
      if (r <= RATIO_SMALL) return band(r, RATIO_STRAIGHT, RATIO_SMALL, sp_straight, sp_small);
      if (r <= RATIO_RIGHT) return band(r, RATIO_SMALL, RATIO_RIGHT, sp_small, sp_right);
      return sp_sharp;
    endfunction

    // Advance the predictor by one accepted input word
    function void note_input(in_word_t w);
      out_word_t   o;
      int          enc_pos;
      int unsigned sd, idx, look, maxr, r;
      logic        took, req;
      enc_pos = w.distance;
      took = 1'b0; req = 1'b0;
      sd = (samp_dist == 0) ? 1 : samp_dist;
      if (!w.cmd) begin
        if (enc_pos - last_pos >= int'(samp_dist) && npoints < NUM_POINTS) begin
          headings[npoints] = w.heading;
          npoints++;
          last_pos = enc_pos;
          took = 1'b1;
        end
      end else if (npoints != 0) begin
        if (replay >= npoints) begin
          last_pos = 0; npoints = 0; replay = 0; req = 1'b1;
        end else begin
          idx = (enc_pos < 0) ? 0 : enc_pos / sd;
          if (idx >= npoints) idx = npoints - 1;
          replay = idx;
          if (idx < npoints - 1) begin
            look = cur_speed / 60;
            if (look > LOOK_MAX) look = LOOK_MAX;
            maxr = 0;
            for (int unsigned i = idx; i < npoints - 1 && i < idx + look; i++) begin
              r = seg_ratio(headings[i], headings[i + 1]);
              if (r > maxr) maxr = r;
            end
            cur_speed = map_speed(maxr);
          end else begin
            cur_speed = sp_small;
          end
        end
      end
      o.speed = cur_speed[11:0];
      o.sampled = took;
      o.path_index = replay[9:0];
      o.reset_request = req;
      pending.push_back(o);
    endfunction

    // Compare one accepted output word with the oldest expectation
    function void check_result(out_word_t got);
      out_word_t e;
      if (pending.size() == 0) begin
        $error("unexpected output word %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.speed !== e.speed) begin
        $error("speed: expected %0d, got %0d", e.speed, got.speed); errors++;
      end
      if (got.sampled !== e.sampled) begin
        $error("sampled: expected %0d, got %0d", e.sampled, got.sampled); errors++;
      end
      if (got.path_index !== e.path_index) begin
        $error("path_index: expected %0d, got %0d", e.path_index, got.path_index);
        errors++;
      end
      if (got.reset_request !== e.reset_request) begin
        $error("reset_request: expected %0d, got %0d", e.reset_request, got.reset_request);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  in_word_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 0;
  out_word_t   out_data;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = REG_POINT_SPACING;
  logic [15:0] cfg_data = '0;

  planner_scoreboard sb = new();
  int  idle_cycles = 0;
  bit  hold_out = 0;
  bit  stim_done = 0;
  int  cur_pos;

  path_record_lookahead_speed_planner_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Note accepted words and check results at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_input(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog on cycles with no traffic
  always @(posedge clk) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("path_record_lookahead_speed_planner_top: mismatch");
      $finish;
    end
  end

  // Receiver stall pattern, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_out) out_stall <= 1;
    else if (stim_done) out_stall <= 0;
    else begin
      case ($urandom_range(0, 3))
        0: out_stall <= 1;
        1: out_stall <= ($urandom_range(0, 7) == 0);
        default: out_stall <= ($urandom_range(0, 1) == 1);
      endcase
    end
  end

  // Drive one word and hold it until accepted
  task automatic send_word(logic c, int enc_pos, int head);
    in_data.cmd <= c;
    in_data.distance <= enc_pos[23:0];
    in_data.heading <= head[15:0];
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drop_valid();
    in_valid <= 0;
  endtask

  task automatic gap(int n);
    drop_valid();
    repeat (n) @(negedge clk);
  endtask

  task automatic drain();
    drop_valid();
    while (sb.pending.size() != 0) @(negedge clk);
    // idle time after the last word has left the output
    repeat (2200) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, val);
  endtask

  task automatic set_all(int sd, int sl, int s0, int s1, int s2, int s3);
    write_reg(REG_POINT_SPACING, 16'(sd));
    write_reg(REG_SEGMENT_LENGTH, 16'(sl));
    write_reg(REG_SPEED_STRAIGHT, 16'(s0));
    write_reg(REG_SPEED_SMALL_CURVE, 16'(s1));
    write_reg(REG_SPEED_RIGHT_ANGLE, 16'(s2));
    write_reg(REG_SPEED_SHARP, 16'(s3));
    cur_pos = 0;
  endtask

  // Random run: mostly record then track sweeps, some noise
  task automatic random_phase(int n);
    int sd, pts, d, h;
    sd = (sb.samp_dist == 0) ? 1 : sb.samp_dist;
    for (int k = 0; k < n; ) begin
      pts = $urandom_range(2, 40);
      h = $urandom_range(0, 65535);
      for (int p = 0; p < pts && k < n; p++, k++) begin
        cur_pos += sd + (($urandom_range(0, 3) == 0) ? $urandom_range(0, sd) : 0);
        if (cur_pos > 8000000) cur_pos = 0;
        case ($urandom_range(0, 3))
          0: h = $urandom_range(0, 65535);
          default: h += $signed($urandom_range(0, 400)) - 200;
        endcase
        send_word(1'b0, cur_pos, h);
        if ($urandom_range(0, 5) == 0) gap($urandom_range(1, 12));
      end
      for (int p = 0; p < pts + 2 && k < n; p++, k++) begin
        case ($urandom_range(0, 9))
          0: d = -$urandom_range(1, 8388608);
          1: d = $urandom_range(0, 8388607);
          default: d = p * sd + $urandom_range(0, sd - 1);
        endcase
        send_word(1'b1, d, $urandom_range(0, 65535));
        if ($urandom_range(0, 5) == 0) gap($urandom_range(1, 12));
      end
      // replay to the last point, then back to the start
      send_word(1'b1, 8388607, 0);
      send_word(1'b1, 0, 0);
      k += 2;
      cur_pos = 0;
      if ($urandom_range(0, 7) == 0) begin
        send_word(1'b0, $urandom_range(0, 16777215) - 8388608, $urandom_range(0, 65535));
        k++;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    cur_pos = 0;

    // Directed: empty path, field extremes, bands, last point
    send_word(1'b1, 100, 0);
    send_word(1'b0, 34, 32767);
    send_word(1'b0, 68, -32768);
    send_word(1'b0, 100, 0);
    send_word(1'b0, 102, 3000);
    send_word(1'b0, 136, 3000);
    send_word(1'b0, 170, 3010);
    send_word(1'b0, 8388607, -1);
    send_word(1'b0, -8388608, 5);
    send_word(1'b1, -8388608, 0);
    send_word(1'b1, 0, 0);
    send_word(1'b1, 34, 0);
    send_word(1'b1, 68, 0);
    send_word(1'b1, 136, 0);
    send_word(1'b1, 8388607, 0);
    send_word(1'b1, 8388607, 0);
    send_word(1'b1, 0, 0);
    drain();

    // Fill the table to its end, then one more record tick
    set_all(1, 255, 4095, 0, 4095, 0);
    for (int i = 1; i <= NUM_POINTS + 1; i++)
      send_word(1'b0, i, $urandom_range(0, 65535));
    for (int i = 0; i < 20; i++) send_word(1'b1, $urandom_range(0, 1100), 0);
    send_word(1'b1, 8388607, 0);
    send_word(1'b1, 0, 0);
    drain();

    // Long receiver hold-off while the sender keeps offering
    set_all(0, 0, 0, 4095, 0, 4095);
    fork
      begin
        hold_out = 1;
        repeat (3000) @(negedge clk);
        hold_out = 0;
      end
      random_phase(40);
    join
    drain();

    set_all(34, 1, 600, 450, 350, 300);
    random_phase(30);
    drain();
    set_all(65535, 1, 2000, 1000, 500, 100);
    random_phase(20);
    drain();
    set_all($urandom_range(1, 200), $urandom_range(1, 255), $urandom_range(0, 4095),
            $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095));
    random_phase(30);
    drain();
    set_all(5, 3, 4095, 4095, 4095, 4095);
    random_phase(20);

    stim_done = 1;
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("path_record_lookahead_speed_planner_top: match");
    else
      $display("path_record_lookahead_speed_planner_top: mismatch");
    $finish;
  end
endmodule

// ===== filelist.f =====
src/prlsp_pkg.sv
src/prlsp_div.sv
src/prlsp_core.sv
src/path_record_lookahead_speed_planner_top.sv
dv/tb.sv
